// File: design/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, request codes, sequencer states and the request type.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int KEY_DEPTH_DEF = 256;
  localparam int BYTE_W        = 8;
  localparam int KEY_LEN_W     = 9;
  localparam int ACT_W         = 2;
  localparam int PERM_SIZE     = 256;

  localparam logic [BYTE_W-1:0]    PERM_LAST     = BYTE_W'(PERM_SIZE - 1);
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CRYPT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RDK,
    ST_KS_RDB,
    ST_KS_WRK,
    ST_KS_WRB,
    ST_CR_RDA,
    ST_CR_RDB,
    ST_CR_WRA,
    ST_CR_WRB,
    ST_CR_RDT,
    ST_CR_OUT
  } rc4_state_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_byte;
  } rc4_cmd_t;

endpackage

`default_nettype wire

// File: design/rc4_if.sv
// ----------------------------------------------------------------------------
// RC4 channel interfaces
// Request, response and key length write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] key_index;
  logic [7:0] data_byte;

  modport source (output valid, output action, output key_index, output data_byte,
                  input ready);
  modport sink   (input valid, input action, input key_index, input data_byte,
                  output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

interface rc4_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] key_length;

  modport source (output valid, output key_length, input ready);
  modport sink   (input valid, input key_length, output ready);
endinterface

`default_nettype wire

// File: design/rc4_key_store.sv
// ----------------------------------------------------------------------------
// RC4 key store
// Key byte memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_key_store import rc4_pkg::*; #(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF,
  localparam int KAW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [KAW-1:0]    waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic [KAW-1:0]    raddr_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [KEY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/rc4_core.sv
// ----------------------------------------------------------------------------
// RC4 core
// Sequencer over a single-port permutation memory: fill, key schedule and
// keystream generation.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_core import rc4_pkg::*; #(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF,
  localparam int KAW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire rc4_cmd_t          cmd_i,
  output logic                   cmd_ready_o,
  input  wire logic [KAW-1:0]    key_last_i,
  output logic      [KAW-1:0]    key_raddr_o,
  input  wire logic [BYTE_W-1:0] key_rdata_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic      [BYTE_W-1:0] res_byte_o
);

  rc4_state_e        state_q, state_d;
  logic [BYTE_W-1:0] cnt_q, cnt_d;
  logic [KAW-1:0]    key_pos_q, key_pos_d;
  logic [BYTE_W-1:0] ia_q, ia_d;
  logic [BYTE_W-1:0] ib_q, ib_d;
  logic [BYTE_W-1:0] t_q, t_d;
  logic [BYTE_W-1:0] u_q, u_d;
  logic [BYTE_W-1:0] data_q, data_d;

  logic [BYTE_W-1:0] mem [PERM_SIZE];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_addr;
  logic [BYTE_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.action == ACT_START) begin
          state_d = ST_FILL;
        end else if (cmd_valid_i && cmd_i.action == ACT_CRYPT) begin
          state_d = ST_CR_RDA;
        end
      end
      ST_FILL:   if (cnt_q == PERM_LAST) state_d = ST_KS_RDK;
      ST_KS_RDK: state_d = ST_KS_RDB;
      ST_KS_RDB: state_d = ST_KS_WRK;
      ST_KS_WRK: state_d = ST_KS_WRB;
      ST_KS_WRB: state_d = (cnt_q == PERM_LAST) ? ST_IDLE : ST_KS_RDK;
      ST_CR_RDA: state_d = ST_CR_RDB;
      ST_CR_RDB: state_d = ST_CR_WRA;
      ST_CR_WRA: state_d = ST_CR_WRB;
      ST_CR_WRB: state_d = ST_CR_RDT;
      ST_CR_RDT: state_d = ST_CR_OUT;
      ST_CR_OUT: if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    key_pos_d   = key_pos_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    t_d         = t_q;
    u_d         = u_q;
    data_d      = data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = cnt_q;
    mem_wdata   = rdata_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_byte_o  = data_q ^ rdata_q;
    key_raddr_o = key_pos_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        data_d      = cmd_i.data_byte;
        if (cmd_valid_i && cmd_i.action == ACT_START) begin
          ia_d      = '0;
          ib_d      = '0;
          cnt_d     = '0;
          key_pos_d = '0;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = cnt_q;
        cnt_d     = BYTE_W'(cnt_q + 1'b1);
      end
      ST_KS_RDK: begin
        mem_re = 1'b1;
      end
      ST_KS_RDB: begin
        ib_d     = BYTE_W'(ib_q + rdata_q + key_rdata_i);
        t_d      = rdata_q;
        mem_re   = 1'b1;
        mem_addr = ib_d;
      end
      ST_KS_WRK: begin
        mem_we = 1'b1;
      end
      ST_KS_WRB: begin
        mem_we    = 1'b1;
        mem_addr  = ib_q;
        mem_wdata = t_q;
        cnt_d     = BYTE_W'(cnt_q + 1'b1);
        key_pos_d = (key_pos_q == key_last_i) ? '0 : KAW'(key_pos_q + 1'b1);
        if (cnt_q == PERM_LAST) begin
          ib_d = '0;
        end
      end
      ST_CR_RDA: begin
        ia_d     = BYTE_W'(ia_q + 1'b1);
        mem_re   = 1'b1;
        mem_addr = ia_d;
      end
      ST_CR_RDB: begin
        ib_d     = BYTE_W'(ib_q + rdata_q);
        t_d      = rdata_q;
        mem_re   = 1'b1;
        mem_addr = ib_d;
      end
      ST_CR_WRA: begin
        u_d      = rdata_q;
        mem_we   = 1'b1;
        mem_addr = ia_q;
      end
      ST_CR_WRB: begin
        mem_we    = 1'b1;
        mem_addr  = ib_q;
        mem_wdata = t_q;
      end
      ST_CR_RDT: begin
        mem_re   = 1'b1;
        mem_addr = BYTE_W'(t_q + u_q);
      end
      ST_CR_OUT: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ia_q    <= '0;
      ib_q    <= '0;
    end else begin
      state_q <= state_d;
      ia_q    <= ia_d;
      ib_q    <= ib_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    key_pos_q <= key_pos_d;
    t_q       <= t_d;
    u_q       <= u_d;
    data_q    <= data_d;
  end

endmodule

`default_nettype wire

// File: design/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key load, key schedule and byte encrypt/decrypt on valid/ready channels.
// ----------------------------------------------------------------------------
// A load request writes one key byte. A start request fills the permutation
// memory and then runs the key schedule with two reads and two writes per
// position. A crypt request is accepted, makes five accesses to the
// single-port permutation memory (two reads, two writes for the swap, one
// keystream read) and then hands its result off.
// The response register lets the next request in while a result waits.
// Write key_length only while the block is idle.
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF,
  localparam int KAW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rc4_in_if.sink     req_i,
  rc4_out_if.source  rsp_o,
  rc4_cfg_if.sink    cfg_i
);

  localparam logic [KEY_LEN_W-1:0] KEY_DEPTH_W = KEY_LEN_W'(KEY_DEPTH);

  logic [KEY_LEN_W-1:0] key_len_q;
  logic [KEY_LEN_W-1:0] key_last_full;
  logic [KAW-1:0]       key_last;
  logic                 key_we;
  logic [KAW-1:0]       key_raddr;
  logic [BYTE_W-1:0]    key_rdata;
  rc4_cmd_t             cmd;
  logic                 cmd_ready;
  logic                 res_valid;
  logic                 res_ready;
  logic [BYTE_W-1:0]    res_byte;
  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    out_byte_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KEY_LEN_RESET;
    end else if (cfg_i.valid) begin
      key_len_q <= cfg_i.key_length;
    end
  end

  always_comb begin
    priority if (key_len_q == '0) begin
      key_last_full = '0;
    end else if (key_len_q > KEY_DEPTH_W) begin
      key_last_full = KEY_LEN_W'(KEY_DEPTH_W - 1'b1);
    end else begin
      key_last_full = KEY_LEN_W'(key_len_q - 1'b1);
    end
  end

  assign key_last = key_last_full[KAW-1:0];

  assign key_we = req_i.valid && req_i.ready && req_i.action == ACT_LOAD &&
                  {1'b0, req_i.key_index} < KEY_DEPTH_W;

  rc4_key_store #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_key_store (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(req_i.key_index[KAW-1:0]),
    .wdata_i(req_i.data_byte),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  assign cmd.action    = req_i.action;
  assign cmd.data_byte = req_i.data_byte;
  assign req_i.ready   = cmd_ready;

  rc4_core #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(req_i.valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .key_last_i (key_last),
    .key_raddr_o(key_raddr),
    .key_rdata_i(key_rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_byte_o (res_byte)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_byte_q <= res_byte;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.out_byte = out_byte_q;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("core result dropped while stalled");

  a_busy_on_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !req_i.ready)
    else $error("request accepted while a result is pending in the core");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(res_valid && res_ready))
    else $error("response raised without a core result");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Loads key bytes, runs key schedules under a range of key lengths and
// checks every crypt response against an in-bench cipher predictor, with
// random bursts on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  localparam int    ITEM_TARGET   = 1800;
  localparam int    SETTLE_CYCLES = 1500;
  localparam int    MAX_PRINT     = 40;
  localparam longint TIMEOUT_NS   = 64'd10_000_000;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] key_index;
    logic [BYTE_W-1:0] data_byte;
  } rc4_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 req_valid      = 1'b0;
  logic [ACT_W-1:0]     req_action     = '0;
  logic [BYTE_W-1:0]    req_key_index  = '0;
  logic [BYTE_W-1:0]    req_data       = '0;
  logic                 rsp_ready      = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic [KEY_LEN_W-1:0] cfg_key_length = '0;

  rc4_in_if  req_if ();
  rc4_out_if rsp_if ();
  rc4_cfg_if cfg_if ();

  assign req_if.valid      = req_valid;
  assign req_if.action     = req_action;
  assign req_if.key_index  = req_key_index;
  assign req_if.data_byte  = req_data;
  assign rsp_if.ready      = rsp_ready;
  assign cfg_if.valid      = cfg_valid;
  assign cfg_if.key_length = cfg_key_length;

  rc4_stream_cipher DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // predictor state
  logic [BYTE_W-1:0]    perm_mem [PERM_SIZE];
  logic [BYTE_W-1:0]    key_mem  [KEY_DEPTH_DEF];
  logic [BYTE_W-1:0]    idx_i       = '0;
  logic [BYTE_W-1:0]    idx_j       = '0;
  logic [KEY_LEN_W-1:0] key_len_reg = KEY_LEN_RESET;
  logic [BYTE_W-1:0]    cipher_q [$];

  // stimulus state
  rc4_req_t req_q [$];
  bit       gen_written [KEY_DEPTH_DEF];
  int       item_cnt   = 0;
  int       err_cnt    = 0;
  logic     req_taken  = 1'b0;
  int       gap_left   = 0;
  int       burst_left = 1;
  int       stall_left = 0;
  int       rx_mode    = 0;
  logic [8:0] rx_cnt   = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("rc4_stream_cipher verification failed");
    $finish;
  end

  function automatic int unsigned sched_len(logic [KEY_LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > KEY_LEN_W'(KEY_DEPTH_DEF)) return KEY_DEPTH_DEF;
    return int'(v);
  endfunction

  function automatic void swap_perm(logic [BYTE_W-1:0] p, logic [BYTE_W-1:0] q);
    logic [BYTE_W-1:0] t;
    t           = perm_mem[p];
    perm_mem[p] = perm_mem[q];
    perm_mem[q] = t;
  endfunction

  function automatic void apply_request(rc4_req_t r);
    int unsigned       n;
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] t;
    case (r.action)
      ACT_LOAD: begin
        key_mem[r.key_index] = r.data_byte;
      end
      ACT_START: begin
        idx_i = '0;
        idx_j = '0;
        n     = sched_len(key_len_reg);
        j     = '0;
        for (int k = 0; k < PERM_SIZE; k++) perm_mem[k] = BYTE_W'(k);
        for (int k = 0; k < PERM_SIZE; k++) begin
          j = BYTE_W'(j + perm_mem[k] + key_mem[k % n]);
          swap_perm(BYTE_W'(k), j);
        end
      end
      ACT_CRYPT: begin
        a     = BYTE_W'(idx_i + 8'd1);
        b     = BYTE_W'(idx_j + perm_mem[a]);
        idx_i = a;
        idx_j = b;
        swap_perm(a, b);
        t     = BYTE_W'(perm_mem[a] + perm_mem[b]);
        cipher_q.push_back(r.data_byte ^ perm_mem[t]);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom);
  endfunction

  function automatic void push_req(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] idx,
                                   logic [BYTE_W-1:0] dat);
    rc4_req_t r;
    r.action    = act;
    r.key_index = idx;
    r.data_byte = dat;
    req_q.push_back(r);
    if (act == ACT_LOAD) gen_written[idx] = 1'b1;
    if (act != ACT_UNUSED) item_cnt++;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINT) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (req_q.size() != 0 || req_valid || cipher_q.size() != 0);
  endtask

  task automatic write_key_length(input logic [KEY_LEN_W-1:0] v);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_key_length <= v;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request acceptance and prediction
  always @(posedge clk) begin
    if (rst_n) begin
      req_taken <= req_valid && req_if.ready;
      if (cfg_valid && cfg_if.ready) key_len_reg = cfg_key_length;
      if (req_valid && req_if.ready) apply_request({req_action, req_key_index, req_data});
    end
  end

  // request driver
  always @(negedge clk) begin : req_drive
    rc4_req_t cur;
    if (rst_n && (!req_valid || req_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur           = req_q.pop_front();
        req_valid     <= 1'b1;
        req_action    <= cur.action;
        req_key_index <= cur.key_index;
        req_data      <= cur.data_byte;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response stall pattern
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cnt = rx_cnt + 9'd1;
      if (rx_cnt == '0) rx_mode = $urandom_range(0, 3);
      if (stall_left != 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: rsp_ready <= 1'b1;
          1: begin
            if ($urandom_range(0, 3) == 0) begin
              stall_left = $urandom_range(0, 3);
              rsp_ready  <= 1'b0;
            end else begin
              rsp_ready <= 1'b1;
            end
          end
          2: begin
            if ($urandom_range(0, 15) == 0) begin
              stall_left = $urandom_range(5, 20);
              rsp_ready  <= 1'b0;
            end else begin
              rsp_ready <= 1'b1;
            end
          end
          default: rsp_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // response monitor
  always @(posedge clk) begin : rsp_check
    logic [BYTE_W-1:0] want;
    if (rst_n && rsp_if.valid && rsp_ready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch($sformatf("out_byte %02h with no crypt request pending",
                                  rsp_if.out_byte));
      end else begin
        want = cipher_q.pop_front();
        if (rsp_if.out_byte !== want)
          report_mismatch($sformatf("out_byte %02h, predicted %02h", rsp_if.out_byte, want));
      end
    end
  end

  initial begin
    int                   n;
    int                   ncr;
    int                   pause_at;
    int                   r;
    int                   sw;
    int                   phase;
    int                   order [KEY_DEPTH_DEF];
    logic [KEY_LEN_W-1:0] new_len;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (3) @(posedge clk);

    // key length zero, field extremes, unused code between requests
    write_key_length('0);
    push_req(ACT_LOAD, 8'h00, 8'hFF);
    push_req(ACT_LOAD, 8'hFF, 8'h00);
    push_req(ACT_LOAD, 8'h01, 8'h5A);
    push_req(ACT_UNUSED, 8'hFF, 8'hFF);
    push_req(ACT_START, 8'hFF, 8'h00);
    push_req(ACT_CRYPT, 8'h00, 8'h00);
    push_req(ACT_CRYPT, 8'hFF, 8'hFF);
    push_req(ACT_CRYPT, 8'h00, 8'h00);
    push_req(ACT_CRYPT, 8'hFF, 8'hFF);
    push_req(ACT_CRYPT, 8'h81, 8'h81);
    push_req(ACT_CRYPT, 8'h7E, 8'h7E);
    push_req(ACT_UNUSED, 8'h00, 8'h00);
    push_req(ACT_CRYPT, 8'h3C, 8'h3C);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_key_length(9'd2);
    push_req(ACT_START, 8'h00, 8'hFF);
    repeat (4) push_req(ACT_CRYPT, rand_byte(), rand_byte());

    phase = 0;
    while (item_cnt < ITEM_TARGET) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (phase)
        0: new_len = 9'd1;
        1: new_len = 9'd256;
        2: new_len = 9'd511;
        3: new_len = 9'd300;
        4: new_len = 9'd0;
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0)      new_len = KEY_LEN_W'($urandom_range(200, 511));
          else if (r == 1) new_len = KEY_LEN_W'($urandom_range(0, 1));
          else             new_len = KEY_LEN_W'($urandom_range(2, 40));
        end
      endcase
      write_key_length(new_len);

      n = sched_len(new_len);
      if (n <= 64) begin
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          sw       = $urandom_range(0, i);
          r        = order[i];
          order[i] = order[sw];
          order[sw] = r;
        end
        for (int i = 0; i < n; i++) push_req(ACT_LOAD, BYTE_W'(order[i]), rand_byte());
      end else begin
        for (int i = 0; i < n; i++)
          if (!gen_written[i]) push_req(ACT_LOAD, BYTE_W'(i), rand_byte());
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4))
          push_req(($urandom_range(0, 1) == 0) ? ACT_UNUSED : ACT_LOAD, rand_byte(), rand_byte());
      push_req(ACT_START, rand_byte(), rand_byte());

      ncr      = $urandom_range(8, 60);
      pause_at = (phase == 0 || $urandom_range(0, 5) == 0) ? ncr / 2 : -1;
      for (int c = 0; c < ncr; c++) begin
        if (c == pause_at) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 4)       push_req(ACT_UNUSED, rand_byte(), rand_byte());
        else if (r < 8)  push_req(ACT_LOAD, rand_byte(), rand_byte());
        else if (r < 10) push_req(ACT_START, rand_byte(), rand_byte());
        push_req(ACT_CRYPT, rand_byte(), rand_byte());
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (cipher_q.size() != 0)
      report_mismatch($sformatf("%0d predicted responses never arrived", cipher_q.size()));
    if (err_cnt == 0) begin
      $display("rc4_stream_cipher verification clean");
    end else begin
      $display("rc4_stream_cipher verification failed");
    end
    $finish;
  end

endmodule

// File: rc4_stream_cipher.f
design/rc4_pkg.sv
design/rc4_if.sv
design/rc4_key_store.sv
design/rc4_core.sv
design/rc4_stream_cipher.sv
tb/tb_top.sv
